FILE: hdl/bprs_pkg.sv
package bprs_pkg;

    localparam int MAX_THREADS = 64;
    localparam int DELAY_BITS  = 16;
    localparam int ID_W        = 6;
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);

    localparam logic [31:0] DELAY_MAX32 = (32'd1 << DELAY_BITS) - 32'd1;

    typedef logic [DELAY_BITS-1:0] t_delay;
    typedef logic [ID_W-1:0]       t_id;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_RESUME  = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_WAIT    = 3'd3,
        OP_SELECT  = 3'd4,
        OP_TICK    = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]  op;
        t_id         thread_id;
        logic [15:0] tick_count;
        logic        start_ready;
    } t_req;

    typedef struct packed {
        t_id        selected_id;
        logic       none_ready;
        logic [6:0] woken_count;
    } t_rsp;

    typedef enum logic [2:0] {
        CA_NONE,
        CA_CREATE,
        CA_RESUME,
        CA_SUSPEND,
        CA_WAIT,
        CA_TICK,
        CA_COMMIT
    } t_cell_act;

    // Broadcast from the controller to every cell
    typedef struct packed {
        t_cell_act act;
        t_id       thread_id;
        t_delay    delay;
        logic      start_ready;
        t_id       idle_id;
        logic      reload;
        logic      clear;
        t_id       sel_id;
    } t_cell_cmd;

    // Travels down the row: lowest round id, lowest ready id, wake count
    typedef struct packed {
        logic       rnd_found;
        t_id        rnd_id;
        logic       rdy_found;
        t_id        rdy_id;
        logic [6:0] count;
    } t_tok;

    function automatic t_delay sat_delay(logic [15:0] ticks);
        logic [31:0] t32;
        t32 = {16'd0, ticks};
        if (t32 > DELAY_MAX32) begin
            return DELAY_MAX32[DELAY_BITS-1:0];
        end
        return t32[DELAY_BITS-1:0];
    endfunction

endpackage

FILE: hdl/bprs_cell.sv
module bprs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bprs_pkg::t_id      i_cell_id,
    input  bprs_pkg::t_cell_cmd i_cmd,
    input  bprs_pkg::t_tok     i_tok,
    output bprs_pkg::t_tok     o_tok
);

    logic             r_ready, n_ready;
    logic             r_round, n_round;
    logic             r_woke, n_woke;
    bprs_pkg::t_delay r_delay, n_delay;
    bprs_pkg::t_tok   r_tok, n_tok;

    logic hit;
    logic tick_on;

    assign hit     = (i_cmd.thread_id == i_cell_id);
    assign tick_on = (i_cell_id != '0) && (i_cell_id < i_cmd.idle_id);

    always_comb begin
        n_ready = r_ready;
        n_round = r_round;
        n_delay = r_delay;
        n_woke  = r_woke;
        case (i_cmd.act)
            bprs_pkg::CA_CREATE: begin
                n_woke = 1'b0;
                if (hit) begin
                    n_delay = '0;
                    if (i_cmd.start_ready) begin
                        n_ready = 1'b1;
                        n_round = 1'b1;
                    end
                end
            end
            bprs_pkg::CA_RESUME: begin
                n_woke = 1'b0;
                if (hit) begin
                    n_ready = 1'b1;
                    n_round = 1'b1;
                end
            end
            bprs_pkg::CA_SUSPEND: begin
                n_woke = 1'b0;
                if (hit) begin
                    n_ready = 1'b0;
                    n_round = 1'b0;
                end
            end
            bprs_pkg::CA_WAIT: begin
                n_woke = 1'b0;
                if (hit) begin
                    n_delay = i_cmd.delay;
                    n_ready = 1'b0;
                    n_round = 1'b0;
                end
            end
            bprs_pkg::CA_TICK: begin
                n_woke = 1'b0;
                if (tick_on && (r_delay != '0)) begin
                    n_delay = r_delay - bprs_pkg::t_delay'(1);
                    if (r_delay == bprs_pkg::t_delay'(1)) begin
                        n_ready = 1'b1;
                        n_round = 1'b1;
                        n_woke  = 1'b1;
                    end
                end
            end
            bprs_pkg::CA_COMMIT: begin
                n_round = (i_cmd.reload ? r_ready : r_round)
                        & ~(i_cmd.clear && (i_cmd.sel_id == i_cell_id));
            end
            default: begin
            end
        endcase
    end

    // Pass the running search and count on to the next cell
    always_comb begin
        n_tok           = i_tok;
        n_tok.rnd_found = i_tok.rnd_found | r_round;
        n_tok.rnd_id    = i_tok.rnd_found ? i_tok.rnd_id : i_cell_id;
        n_tok.rdy_found = i_tok.rdy_found | r_ready;
        n_tok.rdy_id    = i_tok.rdy_found ? i_tok.rdy_id : i_cell_id;
        n_tok.count     = i_tok.count + {6'd0, r_woke};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_round <= 1'b0;
            r_woke  <= 1'b0;
            r_delay <= '0;
        end else begin
            r_ready <= n_ready;
            r_round <= n_round;
            r_woke  <= n_woke;
            r_delay <= n_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

FILE: hdl/bitmap_priority_round_scheduler_unit.sv
// Priority bitmap scheduler with a round set, one cell per thread id.
//
// Requests come in on i_in_valid / i_in_req and are taken at an edge where
// o_in_stall is low; every request gives exactly one response on
// o_out_valid / o_out_rsp, held while i_out_stall is high.
// idle_id is written through i_cfg_we / i_cfg_wdata; the user must do so
// only while no request is open, which the block itself does not enforce.
//
// Create, resume, suspend, wait and unused codes update the cells at the
// accepting edge; the response then passes through S_DONE into the output
// register. Select and tick send a search token down the row of cells, one
// cell per cycle, until it has passed the last cell (S_SCAN); the result
// then passes through S_DONE into the output register.
// One request is open at a time; the next one is taken as soon as the
// previous response sits in the output register, even if it is stalled.
// A stalled output holds the response and, once the pending response is
// ready too, holds off new requests.
// Reset clears all ready and round bits and delays and sets idle_id to 63.
module bitmap_priority_round_scheduler_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bprs_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bprs_pkg::t_rsp o_out_rsp,
    input  logic           i_cfg_we,
    input  bprs_pkg::t_id  i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [bprs_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [2:0]                    r_op, n_op;
    bprs_pkg::t_id                 r_idle, n_idle;
    bprs_pkg::t_rsp                r_res, n_res;
    bprs_pkg::t_rsp                r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    bprs_pkg::t_cell_cmd           cmd;
    bprs_pkg::t_tok                tok [bprs_pkg::MAX_THREADS+1];
    bprs_pkg::t_tok                last;

    logic accept;
    logic scan_done;
    logic out_free;
    logic reload;
    logic eff_found;
    bprs_pkg::t_id eff_id;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign scan_done  = (r_state == S_SCAN)
                     && (r_cnt == bprs_pkg::CNT_W'(bprs_pkg::MAX_THREADS));
    assign out_free   = !r_out_valid || !i_out_stall;

    assign last      = tok[bprs_pkg::MAX_THREADS];
    assign reload    = !last.rnd_found || (last.rnd_id == r_idle);
    assign eff_found = reload ? last.rdy_found : 1'b1;
    assign eff_id    = reload ? last.rdy_id : last.rnd_id;

    // Broadcast to the cells
    always_comb begin
        cmd             = '0;
        cmd.act         = bprs_pkg::CA_NONE;
        cmd.thread_id   = i_in_req.thread_id;
        cmd.delay       = bprs_pkg::sat_delay(i_in_req.tick_count);
        cmd.start_ready = i_in_req.start_ready;
        cmd.idle_id     = r_idle;
        cmd.reload      = reload;
        cmd.clear       = eff_found && (eff_id != r_idle);
        cmd.sel_id      = eff_id;
        if (accept) begin
            unique case (i_in_req.op)
                bprs_pkg::OP_CREATE:  cmd.act = bprs_pkg::CA_CREATE;
                bprs_pkg::OP_RESUME:  cmd.act = bprs_pkg::CA_RESUME;
                bprs_pkg::OP_SUSPEND: cmd.act = bprs_pkg::CA_SUSPEND;
                bprs_pkg::OP_WAIT:    cmd.act = bprs_pkg::CA_WAIT;
                bprs_pkg::OP_TICK:    cmd.act = bprs_pkg::CA_TICK;
                default:              cmd.act = bprs_pkg::CA_NONE;
            endcase
        end else if (scan_done && (r_op == bprs_pkg::OP_SELECT)) begin
            cmd.act = bprs_pkg::CA_COMMIT;
        end
    end

    assign tok[0] = '0;

    for (genvar g = 0; g < bprs_pkg::MAX_THREADS; g++) begin : g_cell
        bprs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (bprs_pkg::ID_W'(g)),
            .i_cmd     (cmd),
            .i_tok     (tok[g]),
            .o_tok     (tok[g+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_idle      = i_cfg_we ? i_cfg_wdata : r_idle;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_in_req.op;
                    n_cnt = '0;
                    n_res = '0;
                    if ((i_in_req.op == bprs_pkg::OP_SELECT)
                        || (i_in_req.op == bprs_pkg::OP_TICK)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_res = '0;
                    if (r_op == bprs_pkg::OP_SELECT) begin
                        n_res.none_ready  = !eff_found;
                        n_res.selected_id = eff_found ? eff_id : r_idle;
                    end else begin
                        n_res.woken_count = last.count;
                    end
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + bprs_pkg::CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idle      <= bprs_pkg::ID_W'(63);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule
